// ----- rtl/core/obsp_pkg.sv -----
// shared types and constants for the odd bit sample packer
// no dependencies; imported by every module of the block
package obsp_pkg;

   localparam int unsigned MaxSampleBitsDef = 32;
   localparam int unsigned SampleW          = 32;
   localparam int unsigned CfgW             = 6;
   localparam int unsigned PendW            = 7;
   localparam int unsigned PendCntW         = 3;
   localparam int unsigned ByteCntW         = 3;
   localparam int unsigned QueueDepth       = 2;
   localparam logic [CfgW-1:0] BitsPerSampleRst = 6'd12;

   typedef struct packed {
      logic [ByteCntW-1:0] nbytes;
      logic                eol;
      logic                clip;
   } obsp_ctrl_type;

   localparam int unsigned CtrlW = $bits(obsp_ctrl_type);

endpackage

// ----- rtl/core/obsp_front.sv -----
// front end: width select, clipping, bit accumulation and byte-command build
// depends on obsp_pkg
module obsp_front
   import obsp_pkg::*;
#(
   parameter int unsigned MAX_SAMPLE_BITS = MaxSampleBitsDef,
   parameter int unsigned WORD_W          = ((MAX_SAMPLE_BITS + PendW + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [CfgW-1:0]     csr_wr_data,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SampleW-1:0]  req_tdata,
   input  logic                req_tlast,
   input  logic                q_full,
   output logic                q_push,
   output logic [WORD_W-1:0]   q_word,
   output obsp_ctrl_type       q_ctrl
);

   localparam int unsigned AccW = MAX_SAMPLE_BITS + PendW;
   localparam int unsigned TotW = $clog2(AccW + 1);
   localparam int unsigned ShW  = $clog2(WORD_W + 1);

   logic [CfgW-1:0]     bps_ff, bps_in;
   logic [PendW-1:0]    pend_bits_ff, pend_bits_in;
   logic [PendCntW-1:0] pend_cnt_ff, pend_cnt_in;
   logic                clip_ff, clip_in;

   logic [CfgW-1:0]     width;
   logic [SampleW-1:0]  maxv;
   logic                over;
   logic [SampleW-1:0]  sample_c;
   logic [AccW-1:0]     acc;
   logic [TotW-1:0]     total;
   logic [2:0]          rem;
   logic                accept;
   logic [ShW-1:0]      shamt;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (bps_ff == '0) begin
         width = CfgW'(1);
      end else if (bps_ff > CfgW'(MAX_SAMPLE_BITS)) begin
         width = CfgW'(MAX_SAMPLE_BITS);
      end else begin
         width = bps_ff;
      end
   end

   // all ones at full width since the shift clears every bit
   assign maxv = ~({SampleW{1'b1}} << width);
   assign over = (req_tdata >> width) != '0;

   always_comb begin
      if (width == CfgW'(1)) begin
         sample_c = SampleW'(|req_tdata);
      end else if (over) begin
         sample_c = maxv;
      end else begin
         sample_c = req_tdata;
      end
   end

   assign acc   = (AccW'(pend_bits_ff) << width) | AccW'(sample_c[MAX_SAMPLE_BITS-1:0]);
   assign total = TotW'(pend_cnt_ff) + TotW'(width);
   assign rem   = total[2:0];
   assign shamt = ShW'(WORD_W) - ShW'(total);

   // left-align the stream bits; low zeros become the line-end padding
   assign q_word       = WORD_W'(acc) << shamt;
   assign q_ctrl.nbytes = ByteCntW'(total >> 3) + ByteCntW'(req_tlast && (rem != '0));
   assign q_ctrl.eol    = req_tlast;
   assign q_ctrl.clip   = clip_in;
   assign q_push        = accept && (q_ctrl.nbytes != '0);

   always_comb begin
      bps_in       = bps_ff;
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      clip_in      = clip_ff | ((width != CfgW'(1)) && over);
      if (csr_wr_en) begin
         bps_in = csr_wr_data;
      end
      if (accept) begin
         if (req_tlast) begin
            pend_bits_in = '0;
            pend_cnt_in  = '0;
         end else begin
            pend_bits_in = acc[PendW-1:0] & ~({PendW{1'b1}} << rem);
            pend_cnt_in  = rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff       <= BitsPerSampleRst;
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
         clip_ff      <= 1'b0;
      end else begin
         bps_ff       <= bps_in;
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
         if (accept) begin
            clip_ff <= clip_in;
         end
      end
   end

endmodule

// ----- rtl/core/obsp_queue.sv -----
// short command queue between front and back end
// depends on obsp_pkg
module obsp_queue
   import obsp_pkg::*;
#(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = count_ff == CW'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/core/obsp_back.sv -----
// back end: shifts queued byte commands out one byte per transfer
// depends on obsp_pkg
module obsp_back
   import obsp_pkg::*;
#(
   parameter int unsigned WORD_W = 40
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  logic [WORD_W-1:0] q_word,
   input  obsp_ctrl_type     q_ctrl,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast,
   output logic              rsp_tuser
);

   logic [WORD_W-1:0]   word_ff, word_in;
   logic [ByteCntW-1:0] left_ff, left_in;
   logic                eol_ff, eol_in;
   logic                clip_ff, clip_in;
   logic                xfer, free;

   assign rsp_tvalid = left_ff != '0;
   assign rsp_tdata  = word_ff[WORD_W-1 -: 8];
   assign rsp_tlast  = eol_ff && (left_ff == ByteCntW'(1));
   assign rsp_tuser  = clip_ff;

   assign xfer  = rsp_tvalid && rsp_tready;
   // current command is done or finishes with this transfer
   assign free  = (left_ff == '0) || ((left_ff == ByteCntW'(1)) && xfer);
   assign q_pop = free && q_valid;

   always_comb begin
      word_in = word_ff;
      left_in = left_ff;
      eol_in  = eol_ff;
      clip_in = clip_ff;
      if (q_pop) begin
         word_in = q_word;
         left_in = q_ctrl.nbytes;
         eol_in  = q_ctrl.eol;
         clip_in = q_ctrl.clip;
      end else if (xfer) begin
         word_in = word_ff << 8;
         left_in = left_ff - ByteCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      eol_ff  <= eol_in;
      clip_ff <= clip_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

endmodule

// ----- rtl/core/odd_bit_sample_packer.sv -----
// MSB-first packer of clipped variable-width samples into a byte stream.
// Input: req_ channel, one 32-bit sample per transfer, req_tlast marks line end.
// Output: rsp_ channel, one packed byte per transfer; rsp_tlast on the final byte
// of a line (partial bytes are zero padded), rsp_tuser is the sticky clip flag.
// csr_wr_en/csr_wr_data set bits_per_sample (0 acts as 1, large values saturate
// to MAX_SAMPLE_BITS); write it only while the block is idle.
// With the byte emitter idle, the first byte of a sample goes through the command
// queue and is registered in the byte emitter before it is valid. A sample is
// accepted every cycle while the two-entry command queue has room; the byte
// emitter sends one byte per cycle while rsp_tready is high, so above 8 bits the
// byte port sets the rate; a sample makes up to 5 bytes at 32 bits with a line-end pad.
// Reset (synchronous, active high) clears buffered bits, the clip flag and the
// queue, and loads bits_per_sample = 12. When rsp_tready is low the byte and the
// queue hold; req_tready drops once the queue is full.
// depends on obsp_pkg, obsp_front, obsp_queue, obsp_back
module odd_bit_sample_packer
   import obsp_pkg::*;
#(
   parameter int unsigned MAX_SAMPLE_BITS = MaxSampleBitsDef
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [CfgW-1:0]    csr_wr_data,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [SampleW-1:0] req_tdata,   // [31:0] sample_value
   input  logic               req_tlast,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,   // [7:0] packed_byte
   output logic               rsp_tlast,
   output logic               rsp_tuser    // [0] clip_seen
);

   localparam int unsigned WordW = ((MAX_SAMPLE_BITS + PendW + 7) / 8) * 8;
   localparam int unsigned EntW  = WordW + CtrlW;

   logic              q_full, q_push, q_valid, q_pop;
   logic [WordW-1:0]  f_word, b_word;
   obsp_ctrl_type     f_ctrl, b_ctrl;
   logic [EntW-1:0]   q_in, q_out;

   obsp_front #(
      .MAX_SAMPLE_BITS(MAX_SAMPLE_BITS),
      .WORD_W         (WordW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_word     (f_word),
      .q_ctrl     (f_ctrl)
   );

   assign q_in = {f_word, f_ctrl};

   obsp_queue #(
      .WIDTH(EntW),
      .DEPTH(QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_in),
      .full     (q_full),
      .pop      (q_pop),
      .pop_valid(q_valid),
      .pop_data (q_out)
   );

   assign b_word = q_out[EntW-1 -: WordW];
   assign b_ctrl = q_out[CtrlW-1:0];

   obsp_back #(
      .WORD_W(WordW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_word    (b_word),
      .q_ctrl    (b_ctrl),
      .q_pop     (q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

endmodule

// ----- verif/tb_odd_bit_sample_packer.sv -----
// testbench for odd_bit_sample_packer: drives samples and width settings, predicts the
// msb-first byte stream with a scoreboard class and checks every byte transfer
// depends on obsp_pkg and odd_bit_sample_packer
`timescale 1ns / 1ps

typedef struct packed {
   logic [7:0] data;
   logic       last;
   logic       clip;
} packed_byte_type;

class packed_byte_scoreboard;
   logic [5:0]      width_reg;
   logic [6:0]      leftover_bits;
   int unsigned     leftover_count;
   logic            clip_sticky;
   packed_byte_type byte_q[$];
   int unsigned     error_count;

   function new();
      width_reg      = obsp_pkg::BitsPerSampleRst;
      leftover_bits  = '0;
      leftover_count = 0;
      clip_sticky    = 1'b0;
      error_count    = 0;
   endfunction

   function void note_width(logic [5:0] value);
      width_reg = value;
   endfunction

   // zero acts as one, anything above the parameter saturates
   function int unsigned width_in_use();
      if (width_reg == 6'd0) return 1;
      if (width_reg > obsp_pkg::MaxSampleBitsDef) return obsp_pkg::MaxSampleBitsDef;
      return width_reg;
   endfunction

   function void note_sample(logic [31:0] sample, logic line_end);
      int unsigned     w;
      int unsigned     total;
      logic [63:0]     value;
      logic [63:0]     acc;
      packed_byte_type item;
      int              n;
      w     = width_in_use();
      value = {32'd0, sample};
      if (w == 1) begin
         value = (sample != 0) ? 64'd1 : 64'd0;
      end else if (value > ((64'd1 << w) - 1)) begin
         value       = (64'd1 << w) - 1;
         clip_sticky = 1'b1;
      end
      acc   = ({57'd0, leftover_bits} << w) | value;
      total = leftover_count + w;
      n     = 0;
      while (total >= 8) begin
         item.data = 8'(acc >> (total - 8));
         item.last = 1'b0;
         item.clip = clip_sticky;
         byte_q.push_back(item);
         n++;
         total -= 8;
      end
      acc &= (64'd1 << total) - 1;
      if (line_end) begin
         if (total > 0) begin
            item.data = 8'(acc << (8 - total));
            item.last = 1'b1;
            item.clip = clip_sticky;
            byte_q.push_back(item);
         end else if (n > 0) begin
            // line ends on a byte boundary: mark the last full byte instead
            byte_q[byte_q.size() - 1].last = 1'b1;
         end
         leftover_bits  = '0;
         leftover_count = 0;
      end else begin
         leftover_bits  = acc[6:0];
         leftover_count = total;
      end
   endfunction

   task report_mismatch(string what);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   task check_byte(logic [7:0] data, logic last, logic clip);
      packed_byte_type want;
      if (byte_q.size() == 0) begin
         report_mismatch($sformatf("byte 0x%02h with nothing expected", data));
      end else begin
         want = byte_q.pop_front();
         if (data !== want.data)
            report_mismatch($sformatf("packed byte 0x%02h, want 0x%02h", data, want.data));
         if (last !== want.last)
            report_mismatch($sformatf("line last %b, want %b", last, want.last));
         if (clip !== want.clip)
            report_mismatch($sformatf("clip flag %b, want %b", clip, want.clip));
      end
   endtask
endclass

module tb_odd_bit_sample_packer;
   import obsp_pkg::*;

   localparam int unsigned CycleLimit = 200000;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [CfgW-1:0]    csr_wr_data;
   logic               req_tvalid;
   logic               req_tready;
   logic [SampleW-1:0] req_tdata;
   logic               req_tlast;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [7:0]         rsp_tdata;
   logic               rsp_tlast;
   logic               rsp_tuser;

   packed_byte_scoreboard byte_sb;
   bit                    idling_on;
   int unsigned           cycle_count = 0;

   odd_bit_sample_packer u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   // byte receiver with random stall bursts
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (idling_on && $urandom_range(0, 6) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(1, 14) - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         byte_sb.check_byte(rsp_tdata, rsp_tlast, rsp_tuser);
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_sample(input logic [31:0] sample, input logic line_end);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      req_tlast  <= line_end;
      do @(posedge clock); while (!req_tready);
      byte_sb.note_sample(sample, line_end);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (byte_sb.byte_q.size() != 0) @(posedge clock);
      // a sample that makes no byte may still be in flight
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_width(input logic [CfgW-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      byte_sb.note_width(value);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [31:0] pick_sample(int unsigned w);
      logic [31:0] limit;
      limit = (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 1);
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom;
         3, 4, 5, 6: return $urandom & limit;
         7: return limit;
         8: return (w >= 32) ? 32'd0 : limit + 1;
         default: return 32'd0;
      endcase
   endfunction

   initial begin
      logic [CfgW-1:0] phase_width;
      byte_sb     = new();
      idling_on   = 1'b1;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset width of 12, no clipping at first so the clear flag is seen
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'h0000_0FFF, 1'b0);
      send_sample(32'h0000_0A5C, 1'b1);
      send_sample(32'h0000_1000, 1'b1);
      // zero behaves as one bit: nonzero packs as 1, padded line end
      write_width(6'd0);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'h0000_0007, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b1);
      // full width, line ending on a byte boundary
      write_width(6'd32);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h8000_0001, 1'b1);
      write_width(6'd63);
      send_sample(32'h1234_5678, 1'b1);
      write_width(6'd8);
      send_sample(32'h0000_01FF, 1'b0);
      send_sample(32'h0000_00AB, 1'b1);
      write_width(6'd7);
      send_sample(32'h0000_007F, 1'b0);
      send_sample(32'h0000_0080, 1'b0);
      send_sample(32'h0000_0055, 1'b0);
      send_sample(32'h0000_002A, 1'b0);
      send_sample(32'h0000_0011, 1'b0);
      send_sample(32'h0000_0006, 1'b0);
      send_sample(32'h0000_0003, 1'b0);
      send_sample(32'h0000_007E, 1'b1);

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: phase_width = 6'd1;
            1: phase_width = 6'd32;
            2: phase_width = 6'd0;
            3: phase_width = 6'd63;
            4: phase_width = 6'($urandom_range(2, 31));
            5: phase_width = 6'($urandom_range(33, 62));
            6: phase_width = 6'd5;
            default: phase_width = 6'($urandom_range(1, 24));
         endcase
         write_width(phase_width);
         // stretches with and without idling, none at the very end
         idling_on = (phase % 3 != 2) && (phase != 7);
         repeat (48)
            send_sample(pick_sample(byte_sb.width_in_use()), $urandom_range(0, 5) == 0);
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (byte_sb.error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
